@@ src/pld_pkg.sv @@
`default_nettype none

package pld_pkg;

    // largest interface name length that a label may carry
    localparam int unsigned IFACE_MAX = 15;

    // fixed field sizes of the label, in bytes
    localparam int unsigned IDENT_BYTES  = 8;
    localparam int unsigned WEIGHT_BYTES = 4;
    localparam int unsigned MASK_BYTES   = 8;

    // parse phases
    typedef enum logic [2:0] {
        PH_IDENT  = 3'd0,
        PH_LEN    = 3'd1,
        PH_NAME   = 3'd2,
        PH_WEIGHT = 3'd3,
        PH_MASK   = 3'd4,
        PH_DONE   = 3'd5,
        PH_ERR    = 3'd6
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_LABEL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_LEN   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    // one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  name_char;
        logic [63:0] path_ident;
        logic [7:0]  name_length;
        logic [31:0] path_weight;
        logic [63:0] class_mask;
        logic [1:0]  error_code;
    } out_item_t;

endpackage

`default_nettype wire

@@ src/pld_stream_if.sv @@
`default_nettype none

interface pld_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/path_label_stream_decoder_core.sv @@
`default_nettype none

// Path label stream decoder. Takes a payload one byte per item (final_byte marks the
// last byte) laid out as an 8-byte big-endian path id, a length byte, that many name
// bytes, a 4-byte big-endian weight and an 8-byte big-endian DSCP mask. Each name byte
// comes out as a kind 0 item, the finished label as one kind 1 record, and a length of
// zero or above IFACE_MAX (code 1) or an early final byte (code 2) as a kind 2 record;
// after an error or a finished label the rest of the payload is dropped. The block
// takes one byte per cycle: a byte is registered at the input, then parsed against the
// phase state and written to the result register, which offers the result on the
// output. Throughput drops only while the result register holds an item that the sink
// has not taken.
module path_label_stream_decoder_core #(
    parameter int unsigned IFACE_MAX = pld_pkg::IFACE_MAX
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    pld_stream_if.sink        bytes,
    pld_stream_if.source      results
);

    // input stage
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    // parse state
    pld_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]           count_reg, count_next;
    logic [63:0]          ident_reg, ident_next;
    logic [7:0]           length_reg, length_next;
    logic [31:0]          weight_reg, weight_next;
    logic [63:0]          mask_reg, mask_next;

    // result stage
    logic                 out_valid_reg;
    pld_pkg::out_item_t   out_item_reg, out_item_next;
    logic                 emit;

    logic                 advance;
    logic [7:0]           count_inc;
    logic                 err_hit;
    logic [1:0]           err_code;

    // an item moves on when the result slot is free or being emptied
    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign bytes.ready = !in_valid_reg || advance;

    assign results.valid = out_valid_reg;
    assign results.data  = out_item_reg;

    assign count_inc = count_reg + 8'd1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            in_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_byte_reg <= bytes.data.data_byte;
            in_last_reg <= bytes.data.final_byte;
        end
    end

    // parse one byte against the current phase
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        ident_next    = ident_reg;
        length_next   = length_reg;
        weight_next   = weight_reg;
        mask_next     = mask_reg;
        out_item_next = '0;
        emit          = 1'b0;
        err_hit       = 1'b0;
        err_code      = pld_pkg::ERR_NONE;

        case (phase_reg)
            pld_pkg::PH_IDENT:
            begin
                ident_next = {ident_reg[55:0], in_byte_reg};
                count_next = count_inc;
                if (count_inc >= 8'(pld_pkg::IDENT_BYTES))
                begin
                    count_next = '0;
                    phase_next = pld_pkg::PH_LEN;
                end
                if (in_last_reg)
                begin
                    err_hit  = 1'b1;
                    err_code = pld_pkg::ERR_TRUNCATED;
                end
            end
            pld_pkg::PH_LEN:
            begin
                if (in_byte_reg == 8'd0 || in_byte_reg > 8'(IFACE_MAX))
                begin
                    err_hit  = 1'b1;
                    err_code = pld_pkg::ERR_BAD_LEN;
                end
                else
                begin
                    length_next = in_byte_reg;
                    count_next  = '0;
                    phase_next  = pld_pkg::PH_NAME;
                    if (in_last_reg)
                    begin
                        err_hit  = 1'b1;
                        err_code = pld_pkg::ERR_TRUNCATED;
                    end
                end
            end
            pld_pkg::PH_NAME:
            begin
                if (in_last_reg)
                begin
                    err_hit  = 1'b1;
                    err_code = pld_pkg::ERR_TRUNCATED;
                end
                else
                begin
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        count_next = '0;
                        phase_next = pld_pkg::PH_WEIGHT;
                    end
                    emit                      = 1'b1;
                    out_item_next.result_kind = pld_pkg::KIND_NAME;
                    out_item_next.name_char   = in_byte_reg;
                end
            end
            pld_pkg::PH_WEIGHT:
            begin
                weight_next = {weight_reg[23:0], in_byte_reg};
                count_next  = count_inc;
                if (count_inc >= 8'(pld_pkg::WEIGHT_BYTES))
                begin
                    count_next = '0;
                    phase_next = pld_pkg::PH_MASK;
                end
                if (in_last_reg)
                begin
                    err_hit  = 1'b1;
                    err_code = pld_pkg::ERR_TRUNCATED;
                end
            end
            pld_pkg::PH_MASK:
            begin
                mask_next  = {mask_reg[55:0], in_byte_reg};
                count_next = count_inc;
                if (count_inc >= 8'(pld_pkg::MASK_BYTES))
                begin
                    emit                      = 1'b1;
                    out_item_next.result_kind = pld_pkg::KIND_LABEL;
                    out_item_next.path_ident  = ident_reg;
                    out_item_next.name_length = length_reg;
                    out_item_next.path_weight = weight_reg;
                    out_item_next.class_mask  = {mask_reg[55:0], in_byte_reg};
                    count_next                = '0;
                    phase_next                = in_last_reg ? pld_pkg::PH_IDENT
                                                            : pld_pkg::PH_DONE;
                end
                else if (in_last_reg)
                begin
                    err_hit  = 1'b1;
                    err_code = pld_pkg::ERR_TRUNCATED;
                end
            end
            default:
            begin
                // done, error or unused phase: drop bytes until the final one
                if (in_last_reg)
                begin
                    phase_next = pld_pkg::PH_IDENT;
                    count_next = '0;
                end
            end
        endcase

        // error record, then rearm on the final byte or skip the rest
        if (err_hit)
        begin
            emit                      = 1'b1;
            out_item_next             = '0;
            out_item_next.result_kind = pld_pkg::KIND_ERROR;
            out_item_next.error_code  = err_code;
            count_next                = in_last_reg ? 8'd0 : count_next;
            phase_next                = in_last_reg ? pld_pkg::PH_IDENT : pld_pkg::PH_ERR;
        end
    end

    // phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pld_pkg::PH_IDENT;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // field shift registers, fully rewritten before each use
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ident_reg  <= ident_next;
            length_reg <= length_next;
            weight_reg <= weight_next;
            mask_reg   <= mask_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire

@@ bench/path_label_stream_decoder_core_tb.sv @@
`default_nettype none

module path_label_stream_decoder_core_tb;

    localparam int unsigned RANDOM_BYTES = 900;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // tracks the label parse and holds the results still owed by the block
    class label_tracker;
        pld_pkg::phase_t    phase;
        logic [7:0]         count;
        logic [63:0]        ident;
        logic [7:0]         len;
        logic [31:0]        weight;
        logic [63:0]        mask;
        pld_pkg::out_item_t owed_results[$];
        int                 mismatches;
        int                 seen_kind[3];

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            phase  = pld_pkg::PH_IDENT;
            count  = '0;
            ident  = '0;
            len    = '0;
            weight = '0;
            mask   = '0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("MISMATCH %s: got %0h, want %0h", what, got, want);
        endtask

        // error record; a final byte rearms the parse, otherwise skip to the end
        function void raise_error(logic [1:0] code, logic last);
            pld_pkg::out_item_t rec;
            rec = '0;
            rec.result_kind = pld_pkg::KIND_ERROR;
            rec.error_code  = code;
            owed_results.push_back(rec);
            if (last)
                clear();
            else
                phase = pld_pkg::PH_ERR;
        endfunction

        // note one accepted byte and queue the result it causes, if any
        function void take_byte(pld_pkg::in_item_t item);
            pld_pkg::out_item_t rec;
            logic [7:0]         b;
            logic               last;
            b    = item.data_byte;
            last = item.final_byte;
            rec  = '0;
            case (phase)
                pld_pkg::PH_IDENT:
                begin
                    ident = {ident[55:0], b};
                    count = count + 8'd1;
                    if (count >= pld_pkg::IDENT_BYTES)
                    begin
                        count = '0;
                        phase = pld_pkg::PH_LEN;
                    end
                    if (last)
                        raise_error(pld_pkg::ERR_TRUNCATED, 1'b1);
                end
                pld_pkg::PH_LEN:
                begin
                    // bad length takes precedence over an early end
                    if (b == 8'd0 || b > pld_pkg::IFACE_MAX)
                        raise_error(pld_pkg::ERR_BAD_LEN, last);
                    else
                    begin
                        len   = b;
                        count = '0;
                        phase = pld_pkg::PH_NAME;
                        if (last)
                            raise_error(pld_pkg::ERR_TRUNCATED, 1'b1);
                    end
                end
                pld_pkg::PH_NAME:
                begin
                    // an early end replaces the name byte
                    if (last)
                        raise_error(pld_pkg::ERR_TRUNCATED, 1'b1);
                    else
                    begin
                        count = count + 8'd1;
                        if (count >= len)
                        begin
                            count = '0;
                            phase = pld_pkg::PH_WEIGHT;
                        end
                        rec.result_kind = pld_pkg::KIND_NAME;
                        rec.name_char   = b;
                        owed_results.push_back(rec);
                    end
                end
                pld_pkg::PH_WEIGHT:
                begin
                    weight = {weight[23:0], b};
                    count  = count + 8'd1;
                    if (count >= pld_pkg::WEIGHT_BYTES)
                    begin
                        count = '0;
                        phase = pld_pkg::PH_MASK;
                    end
                    if (last)
                        raise_error(pld_pkg::ERR_TRUNCATED, 1'b1);
                end
                pld_pkg::PH_MASK:
                begin
                    mask  = {mask[55:0], b};
                    count = count + 8'd1;
                    if (count >= pld_pkg::MASK_BYTES)
                    begin
                        rec.result_kind = pld_pkg::KIND_LABEL;
                        rec.path_ident  = ident;
                        rec.name_length = len;
                        rec.path_weight = weight;
                        rec.class_mask  = mask;
                        rec.error_code  = pld_pkg::ERR_NONE;
                        owed_results.push_back(rec);
                        if (last)
                            clear();
                        else
                        begin
                            count = '0;
                            phase = pld_pkg::PH_DONE;
                        end
                    end
                    else if (last)
                        raise_error(pld_pkg::ERR_TRUNCATED, 1'b1);
                end
                default:
                begin
                    // skipping to the final byte
                    if (last)
                        clear();
                end
            endcase
        endfunction

        // compare one accepted result against the oldest one owed
        task match_result(pld_pkg::out_item_t got);
            pld_pkg::out_item_t want;
            if (owed_results.size() == 0)
            begin
                report("result with nothing owed, kind", got.result_kind, 0);
                return;
            end
            want = owed_results.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", got.result_kind, want.result_kind);
            if (got.name_char !== want.name_char)
                report("name_char", got.name_char, want.name_char);
            if (got.path_ident !== want.path_ident)
                report("path_ident", got.path_ident, want.path_ident);
            if (got.name_length !== want.name_length)
                report("name_length", got.name_length, want.name_length);
            if (got.path_weight !== want.path_weight)
                report("path_weight", got.path_weight, want.path_weight);
            if (got.class_mask !== want.class_mask)
                report("class_mask", got.class_mask, want.class_mask);
            if (got.error_code !== want.error_code)
                report("error_code", got.error_code, want.error_code);
            seen_kind[want.result_kind]++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    pld_stream_if #(.payload_t(pld_pkg::in_item_t))  bytes_if ();
    pld_stream_if #(.payload_t(pld_pkg::out_item_t)) results_if ();

    path_label_stream_decoder_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    label_tracker tracker = new();

    int          burst_left;
    int          bytes_sent;
    int          payloads_sent;
    int unsigned cycles;
    bit          long_hold_req;
    logic [7:0]  payload_q[$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
    end

    // field byte: all zeros, all ones or random, by style
    function automatic logic [7:0] field_byte(int unsigned style);
        if (style == 0)
            return 8'h00;
        if (style == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // well-formed label followed by trail random trailing bytes, possibly none
    function automatic void build_label(int unsigned len, int unsigned trail);
        int unsigned style;
        payload_q.delete();
        style = $urandom_range(0, 5);
        repeat (pld_pkg::IDENT_BYTES) payload_q.push_back(field_byte(style));
        payload_q.push_back(8'(len));
        repeat (len) payload_q.push_back(8'($urandom_range(0, 255)));
        style = $urandom_range(0, 5);
        repeat (pld_pkg::WEIGHT_BYTES) payload_q.push_back(field_byte(style));
        style = $urandom_range(0, 5);
        repeat (pld_pkg::MASK_BYTES) payload_q.push_back(field_byte(style));
        repeat (trail) payload_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // offer one byte in bursts with random gaps, return once it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        pld_pkg::in_item_t item;
        item.data_byte  = b;
        item.final_byte = last;
        if (burst_left == 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        bytes_if.valid <= 1'b1;
        bytes_if.data  <= item;
        do
            @(posedge clk);
        while (bytes_if.ready !== 1'b1);
        tracker.take_byte(item);
        bytes_sent++;
    endtask

    task automatic send_payload();
        foreach (payload_q[i])
            send_byte(payload_q[i], i == payload_q.size() - 1);
        payloads_sent++;
    endtask

    // sender pauses until every owed result is out
    task automatic wait_drained();
        bytes_if.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (tracker.owed_results.size() != 0);
    endtask

    // receiver: stall patterns in spans, long hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned span;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                results_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            for (int c = 0; c < span; c++)
            begin
                case (mode)
                    0:       results_if.ready <= 1'b1;
                    1:       results_if.ready <= 1'($urandom_range(0, 1));
                    2:       results_if.ready <= (c % 4 == 0);
                    default: results_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1)
            tracker.match_result(results_if.data);
    end

    // stimulus
    initial
    begin
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        int          random_start;
        bit          mid_drained;
        bit          second_hold;
        bytes_if.valid <= 1'b0;
        bytes_if.data  <= '0;
        rst_n          <= 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        payloads_sent = 0;
        long_hold_req = 1'b0;
        mid_drained   = 1'b0;
        second_hold   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // lone final byte: early end in the path id
        payload_q = '{8'hA5};
        send_payload();

        // all-ones path id, then 0xFF as length on the final byte: bad length wins
        payload_q.delete();
        repeat (pld_pkg::IDENT_BYTES + 1) payload_q.push_back(8'hFF);
        send_payload();

        // zero path id, longest name, final byte in the name phase: error replaces name
        payload_q.delete();
        repeat (pld_pkg::IDENT_BYTES) payload_q.push_back(8'h00);
        payload_q.push_back(8'(pld_pkg::IFACE_MAX));
        payload_q.push_back(8'h5A);
        send_payload();

        wait_drained();
        random_start  = bytes_sent;
        long_hold_req = 1'b1;

        // random payloads, mostly well-formed labels
        while (bytes_sent < random_start + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 3) == 0)
                   ? ($urandom_range(0, 1) ? 1 : pld_pkg::IFACE_MAX)
                   : $urandom_range(1, pld_pkg::IFACE_MAX);
            if (pick < 60)
                build_label(len, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
            else if (pick < 80)
            begin
                // label cut short at a random byte
                build_label(len, 0);
                cut = $urandom_range(1, payload_q.size() - 1);
                while (payload_q.size() > cut)
                    void'(payload_q.pop_back());
            end
            else if (pick < 95)
            begin
                // length byte of zero or above the limit
                payload_q.delete();
                repeat (pld_pkg::IDENT_BYTES)
                    payload_q.push_back(8'($urandom_range(0, 255)));
                payload_q.push_back(($urandom_range(0, 3) == 0) ? 8'd0
                                    : 8'($urandom_range(pld_pkg::IFACE_MAX + 1, 255)));
                repeat ($urandom_range(0, 4))
                    payload_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                // noise
                payload_q.delete();
                repeat ($urandom_range(1, 30))
                    payload_q.push_back(8'($urandom_range(0, 255)));
            end
            send_payload();

            if (!mid_drained && bytes_sent > random_start + RANDOM_BYTES / 2)
            begin
                mid_drained = 1'b1;
                wait_drained();
            end
            if (!second_hold && bytes_sent > random_start + 2 * RANDOM_BYTES / 3)
            begin
                second_hold   = 1'b1;
                long_hold_req = 1'b1;
            end
        end

        // wind down
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d payloads, %0d bytes; checked %0d name bytes, %0d labels, %0d errors",
                 payloads_sent, bytes_sent, tracker.seen_kind[pld_pkg::KIND_NAME],
                 tracker.seen_kind[pld_pkg::KIND_LABEL],
                 tracker.seen_kind[pld_pkg::KIND_ERROR]);
        $display("included two %0d-cycle receiver hold-offs and three full drains",
                 LONG_HOLD);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
src/pld_pkg.sv
src/pld_stream_if.sv
src/path_label_stream_decoder_core.sv
bench/path_label_stream_decoder_core_tb.sv
